// ===== design/gslc_pkg.sv =====
// ----------------------------------------------------------------------------
// gslc_pkg: shared types and constants for the glyph slot LRU cache
// Field widths, action and plan codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gslc_pkg;

  // default build parameters
  localparam int SLOTS_DEF     = 64;
  localparam int CODE_BITS_DEF = 16;

  // fixed field widths
  localparam int CHAR_W        = 16;
  localparam int ACTION_W      = 2;
  localparam int SLOT_OUT_W    = 6;
  localparam int OUT_TDATA_W   = 32;
  localparam int SLOT_COUNT_W  = 7;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 7'd64;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_SLOT_COUNT = 1'b0;

  // used-mark generation tag; zero means never marked
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FETCH = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PLAN_NONE  = 2'd0,
    PLAN_HIT   = 2'd1,
    PLAN_ALLOC = 2'd2,
    PLAN_EVICT = 2'd3
  } plan_t;

  typedef struct packed {
    logic  accept;
    logic  scan_run;
    logic  plan_valid;
    plan_t plan;
    logic  shift_run;
    logic  front_wr;
    logic  finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;
    logic scan_done;
    logic found;
    logic is_fetch;
    logic room;
    logic shift_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/gslc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gslc_ctrl: sequencer for the glyph slot LRU cache
// Steps one word through scan, decision, recency shift and result.
// ----------------------------------------------------------------------------
module gslc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gslc_pkg::ACTION_W-1:0] s_axis_tuser,
  output gslc_pkg::dp_cmd_t             cmd,
  input  gslc_pkg::dp_stat_t            st
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  gslc_pkg::action_t in_act;

  assign in_act = gslc_pkg::action_t'(s_axis_tuser);
  assign s_axis_tready = (state == ST_IDLE) && !st.clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.plan   = gslc_pkg::PLAN_NONE;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && !st.clearing) begin
          cmd.accept = 1'b1;
          if (in_act == gslc_pkg::ACT_FLUSH || in_act == gslc_pkg::ACT_CLEAR) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.plan_valid = 1'b1;
        priority if (st.found) begin
          cmd.plan = gslc_pkg::PLAN_HIT;
        end else if (!st.is_fetch) begin
          cmd.plan = gslc_pkg::PLAN_NONE;
        end else if (st.room) begin
          cmd.plan = gslc_pkg::PLAN_ALLOC;
        end else begin
          cmd.plan = gslc_pkg::PLAN_EVICT;
        end
        state_next = (cmd.plan == gslc_pkg::PLAN_NONE) ? ST_FINISH : ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (st.shift_done) begin
          cmd.front_wr = 1'b1;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/gslc_datapath.sv =====
// ----------------------------------------------------------------------------
// gslc_datapath: slot store, recency list, used marks and result register
// Memories, scan pipeline, recency shift and mark bookkeeping.
// ----------------------------------------------------------------------------
module gslc_datapath #(
  parameter int SLOTS     = gslc_pkg::SLOTS_DEF,
  parameter int CODE_BITS = gslc_pkg::CODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gslc_pkg::SLOT_COUNT_W-1:0] slot_count,
  input  logic                              cfg_wr,
  input  logic [gslc_pkg::CHAR_W-1:0]       s_axis_tdata,
  input  logic [gslc_pkg::ACTION_W-1:0]     s_axis_tuser,
  input  gslc_pkg::dp_cmd_t                 cmd,
  output gslc_pkg::dp_stat_t                st,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gslc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int CMP_W      = (CNT_W > gslc_pkg::SLOT_COUNT_W) ? CNT_W : gslc_pkg::SLOT_COUNT_W;
  localparam int UT_W       = CODE_BITS + 1;
  localparam int FW         = (UT_W > CNT_W) ? UT_W : CNT_W;
  localparam int MARK_DEPTH = 1 << CODE_BITS;
  localparam int EW         = gslc_pkg::EPOCH_W;

  // storage
  logic [SLOT_W-1:0]    rec_mem  [SLOTS];
  logic [CODE_BITS-1:0] code_mem [SLOTS];
  logic [EW-1:0]        mark_mem [MARK_DEPTH];

  logic [SLOT_W-1:0]    rec_rdata;
  logic [CODE_BITS-1:0] code_rdata;
  logic [EW-1:0]        mark_rdata;

  // word under work
  logic [CODE_BITS-1:0] key;
  gslc_pkg::action_t    act_q;
  logic                 is_fetch;
  logic                 is_wipe;

  // cache fill
  logic [CNT_W-1:0] nfs;
  logic [CNT_W-1:0] n_eff;
  logic [CMP_W-1:0] sc_ext;

  // scan pipeline
  logic [CNT_W-1:0]     issue;
  logic                 issue_go;
  logic                 s1_valid;
  logic [CNT_W-1:0]     s1_pos;
  logic                 s2_valid;
  logic [CNT_W-1:0]     s2_pos;
  logic [SLOT_W-1:0]    s2_slot;
  logic                 match;
  logic                 found;
  logic [CNT_W-1:0]     found_pos;
  logic [SLOT_W-1:0]    found_slot;
  logic [SLOT_W-1:0]    last_slot;
  logic [CODE_BITS-1:0] last_code;

  // recency shift
  logic [CNT_W-1:0]  sh_wp;
  logic [CNT_W-1:0]  sh_wp_m1;
  logic              sh_pend;
  logic [SLOT_W-1:0] sh_pend_addr;
  logic [SLOT_W-1:0] front;
  logic [CNT_W-1:0]  plan_top;
  logic [SLOT_W-1:0] plan_front;

  logic [SLOT_W-1:0] rec_raddr;
  logic              rec_we;
  logic [SLOT_W-1:0] rec_waddr;
  logic [SLOT_W-1:0] rec_wdata;
  logic              code_we;
  logic [SLOT_W-1:0] code_waddr;

  // used marks
  logic [EW-1:0]        epoch;
  logic                 clearing;
  logic [CODE_BITS-1:0] clr_addr;
  logic [UT_W-1:0]      used_total;
  logic [UT_W-1:0]      ut_next;
  logic                 marked;
  logic                 mark_new;
  logic                 bump;

  // result
  logic [SLOT_W-1:0]           res_slot;
  logic                        res_hit;
  logic                        res_render;
  logic                        res_ev_valid;
  logic [gslc_pkg::CHAR_W-1:0] res_ev_char;
  logic                        full;

  assign is_fetch = (act_q == gslc_pkg::ACT_FETCH);
  assign is_wipe  = (act_q == gslc_pkg::ACT_FLUSH) || (act_q == gslc_pkg::ACT_CLEAR);

  // effective slot count: 0 acts as 1, clamp at SLOTS
  assign sc_ext = CMP_W'(slot_count);
  always_comb begin
    if (slot_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (sc_ext > CMP_W'(SLOTS)) begin
      n_eff = CNT_W'(SLOTS);
    end else begin
      n_eff = CNT_W'(sc_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key   <= CODE_BITS'(s_axis_tdata);
      act_q <= gslc_pkg::action_t'(s_axis_tuser);
    end
  end

  // ---------------- scan ----------------
  assign issue_go = (issue < nfs) && !found;
  assign match    = (code_rdata == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_run && issue_go;
      s2_valid <= cmd.scan_run && s1_valid;
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (cmd.scan_run && s2_valid && !found && match) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      issue <= '0;
    end else if (cmd.scan_run && issue_go) begin
      issue <= issue + CNT_W'(1);
    end
    s1_pos  <= issue;
    s2_pos  <= s1_pos;
    s2_slot <= rec_rdata;
    if (cmd.scan_run && s2_valid && !found) begin
      if (match) begin
        found_pos  <= s2_pos;
        found_slot <= s2_slot;
      end else begin
        last_slot <= s2_slot;
        last_code <= code_rdata;
      end
    end
  end

  // ---------------- decision ----------------
  always_comb begin
    plan_top   = '0;
    plan_front = '0;
    unique case (cmd.plan)
      gslc_pkg::PLAN_HIT: begin
        plan_top   = found_pos;
        plan_front = found_slot;
      end
      gslc_pkg::PLAN_ALLOC: begin
        plan_top   = nfs;
        plan_front = nfs[SLOT_W-1:0];
      end
      gslc_pkg::PLAN_EVICT: begin
        plan_top   = nfs - CNT_W'(1);
        plan_front = last_slot;
      end
      default: begin
        plan_top   = '0;
        plan_front = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_slot     <= '0;
      res_hit      <= 1'b0;
      res_render   <= 1'b0;
      res_ev_valid <= 1'b0;
      res_ev_char  <= '0;
    end else if (cmd.plan_valid) begin
      res_slot     <= plan_front;
      res_hit      <= (cmd.plan == gslc_pkg::PLAN_HIT);
      res_render   <= (cmd.plan == gslc_pkg::PLAN_ALLOC) || (cmd.plan == gslc_pkg::PLAN_EVICT);
      res_ev_valid <= (cmd.plan == gslc_pkg::PLAN_EVICT);
      res_ev_char  <= (cmd.plan == gslc_pkg::PLAN_EVICT) ? gslc_pkg::CHAR_W'(last_code) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nfs <= '0;
    end else if (cfg_wr) begin
      nfs <= '0;
    end else if (cmd.finish && act_q == gslc_pkg::ACT_CLEAR) begin
      nfs <= '0;
    end else if (cmd.plan_valid && cmd.plan == gslc_pkg::PLAN_ALLOC) begin
      nfs <= nfs + CNT_W'(1);
    end
  end

  // ---------------- recency shift ----------------
  assign sh_wp_m1 = sh_wp - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_pend <= 1'b0;
    end else if (cmd.plan_valid) begin
      sh_pend <= 1'b0;
    end else if (cmd.shift_run) begin
      sh_pend <= (sh_wp != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan_valid) begin
      sh_wp <= plan_top;
      front <= plan_front;
    end else if (cmd.shift_run && sh_wp != '0) begin
      sh_pend_addr <= sh_wp[SLOT_W-1:0];
      sh_wp        <= sh_wp_m1;
    end
  end

  assign rec_raddr = cmd.shift_run ? sh_wp_m1[SLOT_W-1:0] : issue[SLOT_W-1:0];
  assign rec_we    = cmd.front_wr || (cmd.shift_run && sh_pend);
  assign rec_waddr = cmd.front_wr ? '0 : sh_pend_addr;
  assign rec_wdata = cmd.front_wr ? front : rec_rdata;

  always_ff @(posedge clk) begin
    rec_rdata <= rec_mem[rec_raddr];
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

  assign code_we    = cmd.plan_valid &&
                      (cmd.plan == gslc_pkg::PLAN_ALLOC || cmd.plan == gslc_pkg::PLAN_EVICT);
  assign code_waddr = (cmd.plan == gslc_pkg::PLAN_ALLOC) ? nfs[SLOT_W-1:0] : last_slot;

  always_ff @(posedge clk) begin
    code_rdata <= code_mem[rec_rdata];
    if (code_we) begin
      code_mem[code_waddr] <= key;
    end
  end

  // ---------------- used marks ----------------
  assign marked   = (mark_rdata == epoch);
  assign mark_new = is_fetch && !marked;
  assign bump     = cfg_wr || (cmd.finish && is_wipe);
  assign ut_next  = used_total + UT_W'(mark_new);
  assign full     = !is_wipe && (FW'(ut_next) >= FW'(n_eff));

  always_ff @(posedge clk) begin
    mark_rdata <= mark_mem[key];
    if (clearing) begin
      mark_mem[clr_addr] <= '0;
    end else if (cmd.finish && mark_new) begin
      mark_mem[key] <= epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      epoch    <= gslc_pkg::EPOCH_FIRST;
    end else if (clearing) begin
      // marks are not written while sweeping, so new bumps just ride along
      clr_addr <= clr_addr + CODE_BITS'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end else if (bump && epoch == gslc_pkg::EPOCH_LAST) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      epoch    <= gslc_pkg::EPOCH_FIRST;
    end else if (bump) begin
      epoch <= epoch + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_total <= '0;
    end else if (bump) begin
      used_total <= '0;
    end else if (cmd.finish) begin
      used_total <= ut_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tdata <= {6'd0, full, res_ev_char, res_ev_valid, res_render, res_hit,
                       gslc_pkg::SLOT_OUT_W'(res_slot)};
    end
  end

  assign st.clearing   = clearing;
  assign st.scan_done  = found || (!issue_go && !s1_valid && !s2_valid);
  assign st.found      = found;
  assign st.is_fetch   = is_fetch;
  assign st.room       = (nfs < n_eff);
  assign st.shift_done = (sh_wp == '0) && !sh_pend;
  assign st.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

// ===== design/glyph_slot_lru_cache.sv =====
// ----------------------------------------------------------------------------
// glyph_slot_lru_cache: fully associative LRU map from character codes to
// glyph atlas slots
// Each input word carries an action (fetch, peek, flush marks, clear cache)
// and a character code, and gives exactly one result word: the slot, hit,
// render request, evicted code and the full flag. A fetch or peek scans the
// recency list from most to least recent through one read port, one position
// per cycle through the issue, s1 and s2 pipeline stages, then rotates the
// touched entry to the front one position per cycle. The used-mark store is
// tagged with an 8-bit generation, so flush, clear and a slot_count write
// are instant, except that after reset and after every 255th mark clear a
// sweep over all 2^CODE_BITS tags (65536 by default) wipes them, during
// which no word is taken (register writes still are). A slot_count write
// empties the cache.
// ----------------------------------------------------------------------------
module glyph_slot_lru_cache #(
  parameter int SLOTS     = gslc_pkg::SLOTS_DEF,
  parameter int CODE_BITS = gslc_pkg::CODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gslc_pkg::CHAR_W-1:0]       s_axis_tdata,  // [15:0] char_code
  input  logic [gslc_pkg::ACTION_W-1:0]     s_axis_tuser,  // [1:0] action
  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] slot, [6] hit, [7] render_needed, [8] evicted_valid,
  // [24:9] evicted_char, [25] full_res, [31:26] zero
  output logic [gslc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gslc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gslc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [gslc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [gslc_pkg::SLOT_COUNT_W-1:0] slot_count;
  logic                              cfg_hit;
  logic                              cfg_wr;
  gslc_pkg::dp_cmd_t                 cmd;
  gslc_pkg::dp_stat_t                st;

  // Register file: a single register, slot_count, at byte addresses 0 to 3
  // (paddr[2] low). Writes elsewhere are ignored and read back as zero.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == gslc_pkg::REG_SLOT_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= gslc_pkg::SLOT_COUNT_RST;
    end else if (cfg_wr) begin
      slot_count <= pwdata[gslc_pkg::SLOT_COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = gslc_pkg::CFG_DATA_W'(slot_count);
    end
  end

  // Sequencer: takes a word, walks the scan, picks hit / allocate / evict /
  // no-op, runs the recency rotate, then posts the result once the output
  // register is free.
  gslc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .st            (st)
  );

  // Datapath: slot code store, recency list, used-mark store with its
  // generation tag and wipe sweep, and the result register that decouples
  // the output from the next word.
  gslc_datapath #(
    .SLOTS     (SLOTS),
    .CODE_BITS (CODE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .slot_count    (slot_count),
    .cfg_wr        (cfg_wr),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .st            (st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== sim/glyph_slot_lru_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_slot_lru_cache_tb: self-checking bench for the glyph slot LRU cache
// Drives action/code words on the input stream and writes slot_count over
// the register port. A scoreboard class holds its own copy of the slot map,
// recency list and used marks, works out each result word as its input is
// taken, and compares the result stream against it in order.
// ----------------------------------------------------------------------------
module glyph_slot_lru_cache_tb;

  // one expected result word, unpacked from the output layout
  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        render;
    logic        evicted;
    logic [15:0] evicted_char;
    logic        full;
  } glyph_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks cache contents and predicts one result per input word
  // --------------------------------------------------------------------------
  class glyph_cache_board;
    int            errors;
    glyph_result_t slot_results_q[$];
    logic [6:0]    slot_count;
    logic [15:0]   code_of[64];   // code held by each filled slot
    int            order[64];     // recency list, most recent first
    int            fill;          // filled slots are 0..fill-1
    bit            marked[int];   // used marks since last flush, clear or slot_count write
    int            marked_total;

    function new();
      errors     = 0;
      slot_count = gslc_pkg::SLOT_COUNT_RST;
      empty_cache();
      clear_marks();
    endfunction

    function void empty_cache();
      int i;
      for (i = 0; i < 64; i++) begin
        code_of[i] = '0;
        order[i]   = i;
      end
      fill = 0;
    endfunction

    function void clear_marks();
      marked.delete();
      marked_total = 0;
    endfunction

    // 0 acts as 1, anything above the slot store as the full store
    function int eff_slots();
      if (slot_count == 0) return 1;
      if (slot_count > 64) return 64;
      return int'(slot_count);
    endfunction

    function int find_pos(logic [15:0] code);
      int p;
      for (p = 0; p < fill; p++)
        if (code_of[order[p]] == code) return p;
      return -1;
    endfunction

    function void move_front(int pos);
      int s, p;
      s = order[pos];
      for (p = pos; p > 0; p--) order[p] = order[p-1];
      order[0] = s;
    endfunction

    // grid size change rebuilds the atlas: cache and marks start over
    function void note_config(logic [6:0] val);
      slot_count = val;
      empty_cache();
      clear_marks();
    endfunction

    function void note_word(gslc_pkg::action_t act, logic [15:0] code);
      glyph_result_t r;
      int pos, s, p, last, n;
      n = eff_slots();
      r = '0;
      if (act == gslc_pkg::ACT_FETCH || act == gslc_pkg::ACT_PEEK) begin
        pos = find_pos(code);
        if (pos >= 0) begin
          r.slot = 6'(order[pos]);
          r.hit  = 1'b1;
          move_front(pos);
        end else if (act == gslc_pkg::ACT_FETCH) begin
          r.render = 1'b1;
          if (fill < n) begin
            // take the next never-used slot
            s = fill;
            for (p = fill; p > 0; p--) order[p] = order[p-1];
            order[0]   = s;
            fill++;
            code_of[s] = code;
            r.slot     = 6'(s);
          end else begin
            // evict the least recent slot
            last           = fill - 1;
            s              = order[last];
            r.evicted      = 1'b1;
            r.evicted_char = code_of[s];
            code_of[s]     = code;
            move_front(last);
            r.slot         = 6'(s);
          end
        end
        if (act == gslc_pkg::ACT_FETCH && !marked.exists(int'(code))) begin
          marked[int'(code)] = 1'b1;
          marked_total++;
        end
      end else if (act == gslc_pkg::ACT_FLUSH) begin
        clear_marks();
      end else begin
        empty_cache();
        clear_marks();
      end
      r.full = (marked_total >= n);
      slot_results_q.push_back(r);
    endfunction

    function int pending();
      return slot_results_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [31:0] d);
      glyph_result_t e;
      if (slot_results_q.size() == 0) begin
        report($sformatf("result word 0x%08h with none expected", d));
        return;
      end
      e = slot_results_q.pop_front();
      if (d[5:0] !== e.slot)
        report($sformatf("slot got %0d exp %0d", d[5:0], e.slot));
      if (d[6] !== e.hit)
        report($sformatf("hit got %b exp %b", d[6], e.hit));
      if (d[7] !== e.render)
        report($sformatf("render_needed got %b exp %b", d[7], e.render));
      if (d[8] !== e.evicted)
        report($sformatf("evicted_valid got %b exp %b", d[8], e.evicted));
      if (d[24:9] !== e.evicted_char)
        report($sformatf("evicted_char got 0x%04h exp 0x%04h", d[24:9], e.evicted_char));
      if (d[25] !== e.full)
        report($sformatf("full_res got %b exp %b", d[25], e.full));
      if (d[31:26] !== 6'd0)
        report($sformatf("pad bits got 0x%02h", d[31:26]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [gslc_pkg::CHAR_W-1:0]        s_axis_tdata = '0;    // [15:0] char_code
  logic [gslc_pkg::ACTION_W-1:0]      s_axis_tuser = '0;    // [1:0] action
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  // [5:0] slot, [6] hit, [7] render_needed, [8] evicted_valid,
  // [24:9] evicted_char, [25] full_res, [31:26] zero
  logic [gslc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [gslc_pkg::CFG_ADDR_W-1:0]    paddr = '0;
  logic [gslc_pkg::CFG_DATA_W-1:0]    pwdata = '0;
  logic [gslc_pkg::CFG_DATA_W-1:0]    prdata;
  logic                               pready;

  glyph_slot_lru_cache u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  glyph_cache_board sb = new();
  int               results_seen = 0;
  bit               tx_idle_on = 1'b1;   // per-phase: sender inserts gaps
  bit               rx_idle_on = 1'b1;   // per-phase: receiver stalls

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic gslc_pkg::action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return gslc_pkg::ACT_FETCH;
    if (r < 92) return gslc_pkg::ACT_PEEK;
    if (r < 97) return gslc_pkg::ACT_FLUSH;
    return gslc_pkg::ACT_CLEAR;
  endfunction

  // result monitor: values read at the edge are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      sb.check_result(m_axis_tdata);
    end
  end

  // result sink: random stalls, plus one long hold-off once traffic is
  // flowing so the block backs up and drops s_axis_tready
  initial begin : result_sink
    int stall_left;
    bit long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on) stall_left = idle_len();
      end
    end
  end

  // offer one word and hold it until taken; tvalid stays up when no gap
  // follows so back-to-back words need no re-raise
  task automatic send_word(gslc_pkg::action_t act, logic [15:0] code);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(act, code);
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause until every expected result word is back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // setup-then-access register write; upper data bits are junk the block must ignore
  task automatic write_slot_count(logic [6:0] val);
    logic [gslc_pkg::CFG_DATA_W-1:0] wd;
    wd      = $urandom();
    wd[6:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gslc_pkg::REG_SLOT_COUNT, 2'b00};
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_config(val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one random phase at a given slot_count; codes come mostly from a pool
  // sized around the slot count so hits, fills and evictions all happen
  task automatic run_phase(logic [6:0] count, int words);
    logic [15:0]       pool[$];
    int                n, pool_len, i;
    gslc_pkg::action_t act;
    logic [15:0]       code;
    wait_results_drained();
    write_slot_count(count);
    n        = (count == 0) ? 1 : ((count > 64) ? 64 : int'(count));
    pool_len = $urandom_range(n/2 + 1, 2*n + 2);
    for (i = 0; i < pool_len; i++) pool.push_back(16'($urandom()));
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    for (i = 0; i < words; i++) begin
      act = pick_action();
      if ($urandom_range(0, 99) < 85) code = pool[$urandom_range(0, pool_len-1)];
      else code = 16'($urandom());
      send_word(act, code);
      if (i == words/2 && $urandom_range(0, 1) == 1) wait_results_drained();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset slot count of 64
    send_word(gslc_pkg::ACT_FETCH, 16'h0000);   // fill slot 0
    send_word(gslc_pkg::ACT_FETCH, 16'hFFFF);   // fill slot 1
    send_word(gslc_pkg::ACT_FETCH, 16'h0000);   // hit
    send_word(gslc_pkg::ACT_PEEK,  16'hFFFF);   // peek hit
    send_word(gslc_pkg::ACT_PEEK,  16'h1234);   // peek miss, nothing allocated
    send_word(gslc_pkg::ACT_FETCH, 16'h0000);   // hit, mark already set
    send_word(gslc_pkg::ACT_FLUSH, 16'h0000);
    send_word(gslc_pkg::ACT_FETCH, 16'hFFFF);   // hit, marked again
    send_word(gslc_pkg::ACT_CLEAR, 16'hFFFF);
    send_word(gslc_pkg::ACT_PEEK,  16'hFFFF);   // gone after clear
    send_word(gslc_pkg::ACT_FETCH, 16'h5555);
    send_word(gslc_pkg::ACT_FETCH, 16'hAAAA);

    // single slot: every miss after the first evicts, full after first fetch
    wait_results_drained();
    write_slot_count(7'd1);
    send_word(gslc_pkg::ACT_FETCH, 16'h0001);
    send_word(gslc_pkg::ACT_FETCH, 16'h0002);
    send_word(gslc_pkg::ACT_PEEK,  16'h0002);
    send_word(gslc_pkg::ACT_FETCH, 16'h0001);

    // zero acts as one slot
    wait_results_drained();
    write_slot_count(7'd0);
    send_word(gslc_pkg::ACT_FETCH, 16'h00FF);
    send_word(gslc_pkg::ACT_FETCH, 16'hFF00);

    // above the store size clamps to 64
    wait_results_drained();
    write_slot_count(7'd127);
    send_word(gslc_pkg::ACT_FETCH, 16'h8000);
    send_word(gslc_pkg::ACT_PEEK,  16'h8000);

    // two slots: LRU choice after a hit reorders the list
    wait_results_drained();
    write_slot_count(7'd2);
    send_word(gslc_pkg::ACT_FETCH, 16'h0010);
    send_word(gslc_pkg::ACT_FETCH, 16'h0020);
    send_word(gslc_pkg::ACT_FETCH, 16'h0010);
    send_word(gslc_pkg::ACT_FETCH, 16'h0030);   // evicts 0x0020
    send_word(gslc_pkg::ACT_FLUSH, 16'h0030);

    // random phases across slot counts, extremes included
    run_phase(7'd64, 185);
    run_phase(7'd1, 185);
    run_phase(7'd3, 185);
    run_phase(7'd0, 185);
    run_phase(7'd127, 185);
    run_phase(7'd2, 185);
    run_phase(7'd64, 185);
    run_phase(7'($urandom_range(1, 127)), 185);
    run_phase(7'd8, 185);
    run_phase(7'($urandom_range(33, 63)), 185);

    // drain, then leave room for any stray word
    wait_results_drained();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run incl. the tag sweep
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
